@@ sv/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge, off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/rsm_pkg.sv @@
package rsm_pkg;

  localparam int CMD_W = 2;
  localparam int ADDR_W = 10;
  localparam int OP_W = 5;
  localparam int IMM_W = 31;
  localparam int KIND_W = 2;
  localparam int STAT_W = 3;
  localparam int PC_W = 11;
  localparam int WORD_W = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  localparam logic [OP_W-1:0] OP_PUSH    = 5'd0;
  localparam logic [OP_W-1:0] OP_ADD     = 5'd1;
  localparam logic [OP_W-1:0] OP_SUB     = 5'd2;
  localparam logic [OP_W-1:0] OP_MUL     = 5'd3;
  localparam logic [OP_W-1:0] OP_DIV     = 5'd4;
  localparam logic [OP_W-1:0] OP_MOD     = 5'd5;
  localparam logic [OP_W-1:0] OP_DUP     = 5'd6;
  localparam logic [OP_W-1:0] OP_SQRT    = 5'd7;
  localparam logic [OP_W-1:0] OP_EQ      = 5'd8;
  localparam logic [OP_W-1:0] OP_GT      = 5'd9;
  localparam logic [OP_W-1:0] OP_LT      = 5'd10;
  localparam logic [OP_W-1:0] OP_NE      = 5'd11;
  localparam logic [OP_W-1:0] OP_IF      = 5'd12;
  localparam logic [OP_W-1:0] OP_WHILE   = 5'd13;
  localparam logic [OP_W-1:0] OP_ENDLOOP = 5'd14;
  localparam logic [OP_W-1:0] OP_ENDIF   = 5'd15;
  localparam logic [OP_W-1:0] OP_PRNUM   = 5'd16;
  localparam logic [OP_W-1:0] OP_PRCHR   = 5'd17;
  localparam logic [OP_W-1:0] OP_SWAP    = 5'd18;
  localparam logic [OP_W-1:0] OP_DROP    = 5'd19;
  localparam logic [OP_W-1:0] OP_MET     = 5'd20;
  localparam logic [OP_W-1:0] OP_UNMET   = 5'd21;

  localparam logic [STAT_W-1:0] ST_RUN     = 3'd0;
  localparam logic [STAT_W-1:0] ST_END     = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNDER   = 3'd3;
  localparam logic [STAT_W-1:0] ST_OVER    = 3'd4;
  localparam logic [STAT_W-1:0] ST_DIVZERO = 3'd5;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NUM  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHR  = 2'd2;

  typedef logic [1:0] au_op_t;
  localparam au_op_t AU_DIV  = 2'd0;
  localparam au_op_t AU_MOD  = 2'd1;
  localparam au_op_t AU_SQRT = 2'd2;

  typedef struct packed {
    logic   start;
    au_op_t op;
  } au_req_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IMM_W-1:0] imm;
  } prog_word_t;

endpackage

@@ sv/rsm_if.sv @@
interface rsm_in_if;
  import rsm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] address;
  logic [OP_W-1:0]   opcode;
  logic [IMM_W-1:0]  immediate;
  logic              last_token;

  modport source (output valid, command, address, opcode, immediate, last_token,
                  input ready);
  modport sink (input valid, command, address, opcode, immediate, last_token,
                output ready);
endinterface

interface rsm_out_if;
  import rsm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        print_kind;
  logic signed [WORD_W-1:0] print_value;
  logic [STAT_W-1:0]        run_status;
  logic [PC_W-1:0]          program_counter;

  modport source (output valid, print_kind, print_value, run_status, program_counter,
                  input ready);
  modport sink (input valid, print_kind, print_value, run_status, program_counter,
                output ready);
endinterface

@@ sv/rsm_arith_unit.sv @@
// Iterative divide / modulo (one quotient bit a cycle) and integer square
// root (one result bit a cycle). done pulses for one cycle with result valid.
module rsm_arith_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rsm_pkg::au_req_t         req,
  input  logic [rsm_pkg::WORD_W-1:0] opa,
  input  logic [rsm_pkg::WORD_W-1:0] opb,
  output logic                     done,
  output logic [rsm_pkg::WORD_W-1:0] result
);
  import rsm_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  au_op_t            op_r, op_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;   // remainder / radicand left
  logic [WORD_W-1:0] wrk_r, wrk_nxt;   // dividend-quotient / root
  logic [WORD_W-1:0] aux_r, aux_nxt;   // divisor / sqrt bit
  logic              negq_r, negq_nxt;
  logic              negr_r, negr_nxt;
  logic [WORD_W:0]   rsh;
  logic [WORD_W:0]   dif;
  logic [WORD_W-1:0] tsum;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    acc_nxt  = acc_r;
    wrk_nxt  = wrk_r;
    aux_nxt  = aux_r;
    negq_nxt = negq_r;
    negr_nxt = negr_r;
    rsh  = {acc_r, wrk_r[WORD_W-1]};
    dif  = rsh - {1'b0, aux_r};
    tsum = wrk_r + aux_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      if (req.op == AU_SQRT) begin
        acc_nxt = opa;
        wrk_nxt = '0;
        aux_nxt = 32'h4000_0000;
        cnt_nxt = 6'd16;
      end else begin
        acc_nxt  = '0;
        wrk_nxt  = opa[WORD_W-1] ? (32'd0 - opa) : opa;
        aux_nxt  = opb[WORD_W-1] ? (32'd0 - opb) : opb;
        negq_nxt = opa[WORD_W-1] ^ opb[WORD_W-1];
        negr_nxt = opa[WORD_W-1];
        cnt_nxt  = 6'd32;
      end
    end else if (busy_r) begin
      if (op_r == AU_SQRT) begin
        if (acc_r >= tsum) begin
          acc_nxt = acc_r - tsum;
          wrk_nxt = (wrk_r >> 1) + aux_r;
        end else begin
          wrk_nxt = wrk_r >> 1;
        end
        aux_nxt = aux_r >> 2;
      end else begin
        if (!dif[WORD_W]) begin
          acc_nxt = dif[WORD_W-1:0];
          wrk_nxt = {wrk_r[WORD_W-2:0], 1'b1};
        end else begin
          acc_nxt = rsh[WORD_W-1:0];
          wrk_nxt = {wrk_r[WORD_W-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    op_r   <= op_nxt;
    acc_r  <= acc_nxt;
    wrk_r  <= wrk_nxt;
    aux_r  <= aux_nxt;
    negq_r <= negq_nxt;
    negr_r <= negr_nxt;
  end

  assign done = done_r;

  always_comb begin
    case (op_r)
      AU_DIV:  result = negq_r ? (32'd0 - wrk_r) : wrk_r;
      AU_MOD:  result = negr_r ? (32'd0 - acc_r) : acc_r;
      default: result = wrk_r;
    endcase
  end
endmodule

@@ sv/rpn_stack_machine_core_unit.sv @@
// Channel | dir | payload                                          | handshake
// in_ch   | in  | command address opcode immediate last_token       | valid/ready
// out_ch  | out | print_kind print_value run_status program_counter | valid/ready
//
// Load, restart and idle commands go from idle to the finish state, as does a
// step on a halted or finished machine. A step fetches the token; push and flow
// tokens then finish, stack operators read one or two slots and execute (mul and
// swap add a write-back state, div/mod and sqrt wait on the iterative unit), and
// a skip scan reads program memory one slot a cycle. Reset is synchronous, active
// low, and clears the run state; both memories hold garbage until written.
// A finished result waits in the output register while the next request
// is taken; only a second finished result stalls on out_ch.ready.
module rpn_stack_machine_core_unit #(
  parameter int PROGRAM_DEPTH = 1024,
  parameter int STACK_DEPTH   = 256
) (
  input logic     clk,
  input logic     rst_n,
  rsm_in_if.sink  in_ch,
  rsm_out_if.source out_ch
);
  import rsm_pkg::*;

  localparam int PW  = $clog2(PROGRAM_DEPTH);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_RD1   = 4'd2;
  localparam logic [3:0] S_RD2   = 4'd3;
  localparam logic [3:0] S_EXEC  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_UNIT  = 4'd6;
  localparam logic [3:0] S_SWAP  = 4'd7;
  localparam logic [3:0] S_SCAN  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
  localparam logic [SPW-1:0] SP_ONE  = SPW'(1);
  localparam logic [SPW-1:0] SP_TWO  = SPW'(2);

  // memories
  prog_word_t        prog_mem [PROGRAM_DEPTH];
  prog_word_t        prog_q_r;
  logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
  logic [WORD_W-1:0] stack_q_r;

  logic              pm_we, pm_re;
  logic [PW-1:0]     pm_waddr, pm_raddr;
  prog_word_t        pm_wdata;
  logic              st_we, st_re;
  logic [SAW-1:0]    st_waddr, st_raddr;
  logic [WORD_W-1:0] st_wdata;

  // run state
  logic [3:0]        state_r, state_nxt;
  logic [SPW-1:0]    sp_r, sp_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic              skip_r, skip_nxt;
  logic [PC_W-1:0]   lrp_r, lrp_nxt;
  logic [PC_W-1:0]   len_r, len_nxt;
  logic [STAT_W-1:0] halt_r, halt_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [WORD_W-1:0] a_r, a_nxt;
  logic [WORD_W-1:0] b_r, b_nxt;
  logic [WORD_W-1:0] mul_r, mul_nxt;
  logic [PC_W-1:0]   j_r, j_nxt;
  logic [KIND_W-1:0] pkind_r, pkind_nxt;
  logic [WORD_W-1:0] pval_r, pval_nxt;

  // output register
  logic              ov_r, ov_nxt;
  logic [KIND_W-1:0] okind_r, okind_nxt;
  logic [WORD_W-1:0] oval_r, oval_nxt;
  logic [STAT_W-1:0] ostat_r, ostat_nxt;
  logic [PC_W-1:0]   opc_r, opc_nxt;

  au_req_t           au_req;
  logic              au_done;
  logic [WORD_W-1:0] au_res;
  logic [WORD_W-1:0] au_a;

  logic [PC_W-1:0]   pc1;
  logic [PC_W-1:0]   jn;
  logic [OP_W-1:0]   fop;
  logic [OP_W-1:0]   scan_tgt;
  logic [SAW-1:0]    top_a, sec_a;

  assign in_ch.ready = (state_r == S_IDLE);
  assign pc1      = pc_r + 11'd1;
  assign jn       = j_r + 11'd1;
  assign fop      = prog_q_r.op;
  assign scan_tgt = (op_r == OP_IF) ? OP_ENDIF : OP_ENDLOOP;
  assign top_a    = SAW'(sp_r - SP_ONE);
  assign sec_a    = SAW'(sp_r - SP_TWO);
  assign au_a     = (op_r == OP_SQRT) ? b_r : a_r;

  rsm_arith_unit u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (au_req),
    .opa    (au_a),
    .opb    (b_r),
    .done   (au_done),
    .result (au_res)
  );

  always_comb begin
    state_nxt = state_r;
    sp_nxt    = sp_r;
    pc_nxt    = pc_r;
    skip_nxt  = skip_r;
    lrp_nxt   = lrp_r;
    len_nxt   = len_r;
    halt_nxt  = halt_r;
    op_nxt    = op_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    mul_nxt   = mul_r;
    j_nxt     = j_r;
    pkind_nxt = pkind_r;
    pval_nxt  = pval_r;
    ov_nxt    = ov_r & ~out_ch.ready;
    okind_nxt = okind_r;
    oval_nxt  = oval_r;
    ostat_nxt = ostat_r;
    opc_nxt   = opc_r;
    pm_we = 1'b0; pm_waddr = '0; pm_wdata = '0;
    pm_re = 1'b0; pm_raddr = '0;
    st_we = 1'b0; st_waddr = '0; st_wdata = '0;
    st_re = 1'b0; st_raddr = '0;
    au_req = '0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          pkind_nxt = KIND_NONE;
          pval_nxt  = '0;
          state_nxt = S_FIN;
          case (in_ch.command)
            CMD_LOAD: begin
              if (32'(in_ch.address) < PROGRAM_DEPTH) begin
                pm_we    = 1'b1;
                pm_waddr = PW'(in_ch.address);
                pm_wdata = '{op: in_ch.opcode, imm: in_ch.immediate};
                if (in_ch.last_token) len_nxt = PC_W'(in_ch.address) + 11'd1;
              end
            end
            CMD_STEP: begin
              if (halt_r == ST_RUN) begin
                if (pc_r >= len_r) begin
                  halt_nxt = ST_END;
                end else begin
                  pm_re     = 1'b1;
                  pm_raddr  = PW'(pc_r);
                  state_nxt = S_FETCH;
                end
              end
            end
            CMD_RESTART: begin
              sp_nxt   = '0;
              pc_nxt   = '0;
              skip_nxt = 1'b0;
              lrp_nxt  = '0;
              halt_nxt = ST_RUN;
            end
            default: ;
          endcase
        end
      end

      S_FETCH: begin
        op_nxt    = fop;
        state_nxt = S_FIN;
        if (fop == OP_PUSH) begin
          if (sp_r >= SP_FULL) begin
            halt_nxt = ST_OVER;
          end else begin
            st_we    = 1'b1;
            st_waddr = SAW'(sp_r);
            st_wdata = {1'b0, prog_q_r.imm};
            sp_nxt   = sp_r + SP_ONE;
            pc_nxt   = pc1;
          end
        end else if (fop == OP_DUP) begin
          if (sp_r < SP_ONE) halt_nxt = ST_UNDER;
          else if (sp_r >= SP_FULL) halt_nxt = ST_OVER;
          else begin
            st_re = 1'b1; st_raddr = top_a; state_nxt = S_RD1;
          end
        end else if (fop inside {[OP_ADD:OP_MOD], [OP_EQ:OP_NE], OP_SWAP}) begin
          if (sp_r < SP_TWO) halt_nxt = ST_UNDER;
          else begin
            st_re = 1'b1; st_raddr = top_a; state_nxt = S_RD1;
          end
        end else if (fop inside {OP_SQRT, OP_PRNUM, OP_PRCHR, OP_DROP}) begin
          if (sp_r < SP_ONE) halt_nxt = ST_UNDER;
          else begin
            st_re = 1'b1; st_raddr = top_a; state_nxt = S_RD1;
          end
        end else if (fop inside {OP_IF, OP_WHILE}) begin
          if (fop == OP_WHILE) lrp_nxt = pc_r;
          if (!skip_r) begin
            pc_nxt = pc1;
          end else if (pc1 >= len_r) begin
            pc_nxt = len_r;
          end else begin
            pm_re     = 1'b1;
            pm_raddr  = PW'(pc1);
            j_nxt     = pc1;
            state_nxt = S_SCAN;
          end
        end else if (fop == OP_ENDLOOP) begin
          pc_nxt = lrp_r;
        end else if (fop == OP_ENDIF) begin
          pc_nxt = pc1;
        end else if (fop == OP_MET) begin
          skip_nxt = 1'b1; pc_nxt = pc1;
        end else if (fop == OP_UNMET) begin
          skip_nxt = 1'b0; pc_nxt = pc1;
        end else begin
          halt_nxt = ST_UNKNOWN;
        end
      end

      S_RD1: begin
        b_nxt = stack_q_r;
        if (op_r inside {[OP_ADD:OP_MOD], [OP_EQ:OP_NE], OP_SWAP}) begin
          st_re = 1'b1; st_raddr = sec_a; state_nxt = S_RD2;
        end else begin
          state_nxt = S_EXEC;
        end
      end

      S_RD2: begin
        a_nxt     = stack_q_r;
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        state_nxt = S_FIN;
        case (op_r)
          OP_DUP: begin
            st_we = 1'b1; st_waddr = SAW'(sp_r); st_wdata = b_r;
            sp_nxt = sp_r + SP_ONE; pc_nxt = pc1;
          end
          OP_ADD, OP_SUB: begin
            st_we = 1'b1; st_waddr = sec_a;
            st_wdata = (op_r == OP_ADD) ? (a_r + b_r) : (a_r - b_r);
            sp_nxt = sp_r - SP_ONE; pc_nxt = pc1;
          end
          OP_MUL: begin
            mul_nxt   = a_r * b_r;
            state_nxt = S_MUL;
          end
          OP_DIV, OP_MOD: begin
            if (b_r == '0) begin
              halt_nxt = ST_DIVZERO;
            end else begin
              au_req.start = 1'b1;
              au_req.op    = (op_r == OP_DIV) ? AU_DIV : AU_MOD;
              state_nxt    = S_UNIT;
            end
          end
          OP_SQRT: begin
            if (b_r[WORD_W-1]) begin
              st_we = 1'b1; st_waddr = top_a; st_wdata = '0; pc_nxt = pc1;
            end else begin
              au_req.start = 1'b1;
              au_req.op    = AU_SQRT;
              state_nxt    = S_UNIT;
            end
          end
          OP_EQ, OP_GT, OP_LT, OP_NE: begin
            case (op_r)
              OP_EQ:   skip_nxt = (a_r != b_r);
              OP_GT:   skip_nxt = ($signed(a_r) > $signed(b_r));
              OP_LT:   skip_nxt = ($signed(a_r) < $signed(b_r));
              default: skip_nxt = (a_r == b_r);
            endcase
            sp_nxt = sp_r - SP_TWO; pc_nxt = pc1;
          end
          OP_SWAP: begin
            st_we = 1'b1; st_waddr = sec_a; st_wdata = b_r;
            state_nxt = S_SWAP;
          end
          OP_PRNUM: begin
            pkind_nxt = KIND_NUM; pval_nxt = b_r; pc_nxt = pc1;
          end
          OP_PRCHR: begin
            pkind_nxt = KIND_CHR; pval_nxt = {24'd0, b_r[7:0]};
            sp_nxt = sp_r - SP_ONE; pc_nxt = pc1;
          end
          OP_DROP: begin
            sp_nxt = sp_r - SP_ONE; pc_nxt = pc1;
          end
          default: ;
        endcase
      end

      S_MUL: begin
        st_we = 1'b1; st_waddr = sec_a; st_wdata = mul_r;
        sp_nxt = sp_r - SP_ONE; pc_nxt = pc1;
        state_nxt = S_FIN;
      end

      S_UNIT: begin
        if (au_done) begin
          st_we    = 1'b1;
          st_wdata = au_res;
          if (op_r == OP_SQRT) begin
            st_waddr = top_a;
          end else begin
            st_waddr = sec_a;
            sp_nxt   = sp_r - SP_ONE;
          end
          pc_nxt    = pc1;
          state_nxt = S_FIN;
        end
      end

      S_SWAP: begin
        st_we = 1'b1; st_waddr = top_a; st_wdata = a_r;
        pc_nxt = pc1; state_nxt = S_FIN;
      end

      // prog_q_r holds the slot at j_r; next slot read is issued meanwhile
      S_SCAN: begin
        if (fop == scan_tgt) begin
          pc_nxt = jn; state_nxt = S_FIN;
        end else if (jn >= len_r) begin
          pc_nxt = len_r; state_nxt = S_FIN;
        end else begin
          pm_re = 1'b1; pm_raddr = PW'(jn); j_nxt = jn;
        end
      end

      S_FIN: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          okind_nxt = pkind_r;
          oval_nxt  = pval_r;
          ostat_nxt = halt_r;
          opc_nxt   = pc_r;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pm_we) prog_mem[pm_waddr] <= pm_wdata;
    if (pm_re) prog_q_r <= prog_mem[pm_raddr];
  end

  always_ff @(posedge clk) begin
    if (st_we) stack_mem[st_waddr] <= st_wdata;
    if (st_re) stack_q_r <= stack_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sp_r    <= '0;
      pc_r    <= '0;
      skip_r  <= 1'b0;
      lrp_r   <= '0;
      len_r   <= '0;
      halt_r  <= ST_RUN;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      pc_r    <= pc_nxt;
      skip_r  <= skip_nxt;
      lrp_r   <= lrp_nxt;
      len_r   <= len_nxt;
      halt_r  <= halt_nxt;
      ov_r    <= ov_nxt;
    end
    op_r    <= op_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    mul_r   <= mul_nxt;
    j_r     <= j_nxt;
    pkind_r <= pkind_nxt;
    pval_r  <= pval_nxt;
    okind_r <= okind_nxt;
    oval_r  <= oval_nxt;
    ostat_r <= ostat_nxt;
    opc_r   <= opc_nxt;
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.print_kind      = okind_r;
  assign out_ch.print_value     = oval_r;
  assign out_ch.run_status      = ostat_r;
  assign out_ch.program_counter = opc_r;
endmodule

@@ sv/rsm_checker.sv @@
`include "assert_macros.svh"

module rsm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rsm_pkg::KIND_W-1:0] print_kind,
  input logic [rsm_pkg::WORD_W-1:0] print_value,
  input logic [rsm_pkg::STAT_W-1:0] run_status,
  input logic [rsm_pkg::PC_W-1:0]   program_counter
);
  import rsm_pkg::*;

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(print_value) && $stable(run_status) && $stable(program_counter), "result changed while stalled")
  `ASSERT_NOW(a_quiet_zero, out_valid && print_kind == KIND_NONE, print_value == '0, "print value set with nothing printed")
  `ASSERT_NOW(a_chr_byte, out_valid && print_kind == KIND_CHR, print_value[31:8] == '0, "character wider than a byte")
  `ASSERT_NOW(a_print_runs, out_valid && print_kind != KIND_NONE, run_status == ST_RUN, "print on a halted step")
endmodule

bind rpn_stack_machine_core_unit rsm_checker u_rsm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .print_kind      (out_ch.print_kind),
  .print_value     (out_ch.print_value),
  .run_status      (out_ch.run_status),
  .program_counter (out_ch.program_counter)
);
